### hw/rtl/extended_to_double_convert_assert.svh
// assertion macros for the extended to double converter
// used by the top converter module, needs clk and rst in scope
`ifndef EXTENDED_TO_DOUBLE_CONVERT_ASSERT_SVH
`define EXTENDED_TO_DOUBLE_CONVERT_ASSERT_SVH

// implication checked every clock outside reset
`define ETD_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// implication checked on the following clock
`define ETD_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

### hw/rtl/etd_pkg.sv
// shared types and constants for the extended to double converter
// no dependencies
package etd_pkg;
  localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

  typedef enum logic [2:0] {
    CLS_ZERO = 3'b001,
    CLS_SPEC = 3'b010,
    CLS_NUM  = 3'b100
  } cls_t;

  // decoded item passed from normalize to round
  typedef struct packed {
    logic        sign;
    cls_t        cls;
    logic [63:0] spec_bits;
    logic [63:0] mant;
    logic signed [16:0] be;
  } norm_t;
endpackage

### hw/rtl/extended_to_double_convert.sv
// extended (80-bit) to binary64 converter, one value per cycle
// result strobe: done follows the start transfer through the in_valid and done registers
// throughput: one transfer per cycle, busy is always low
// reset: synchronous active high rst clears the valid pipeline only
// the receiver cannot stall, each result shows for one cycle
// depends on etd_pkg, etd_normalize, etd_round
module extended_to_double_convert import etd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] mantissa_bits,
  input  logic [15:0] sign_exponent,
  output logic        done,
  output logic [63:0] double_bits
);
  `include "extended_to_double_convert_assert.svh"

  // input register stage
  logic [63:0] in_mant;
  logic [15:0] in_se;
  logic        in_valid;
  norm_t       norm;
  logic [63:0] res_next;

  // the pipeline never holds off a transfer
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      in_valid <= start;
      done <= in_valid;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (start) begin
      in_mant <= mantissa_bits;
      in_se <= sign_exponent;
    end
    if (in_valid) begin
      double_bits <= res_next;
    end
  end

  // decode, count leading zeros, normalize
  etd_normalize u_norm (
    .mantissa_bits(in_mant),
    .sign_exponent(in_se),
    .norm(norm)
  );

  // single rounding to nearest even, overflow and underflow
  etd_round u_round (
    .norm(norm),
    .double_bits(res_next)
  );

  `ETD_ASSERT_NEXT(a_start_done, start, ##1 done, "start did not give a result")
  `ETD_ASSERT_NEXT(a_sign_kept, in_valid, double_bits[63] == $past(in_se[15]),
    "sign not carried")
  `ETD_ASSERT_IMP(a_zero_exp, in_valid && in_se[14:0] == 15'd0,
    res_next[62:0] == 63'd0, "zero exponent not zero")
endmodule

### hw/rtl/etd_normalize.sv
// classify and normalize one extended value
// depends on etd_pkg
module etd_normalize import etd_pkg::*; (
  input  logic [63:0] mantissa_bits,
  input  logic [15:0] sign_exponent,
  output norm_t       norm
);
  logic [14:0] e;
  logic [6:0]  lz;
  logic        found;

  assign e = sign_exponent[14:0];

  // leading zero count, priority search
  always_comb begin
    lz = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && mantissa_bits[i]) begin
        lz = 7'(63 - i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    norm.sign = sign_exponent[15];
    norm.mant = mantissa_bits << lz[5:0];
    norm.be = $signed({2'b00, e}) - 17'sd15360 - $signed({10'd0, lz});
    norm.spec_bits = 64'd0;
    if (e == EXT_EXP_MAX) begin
      norm.cls = CLS_SPEC;
      if (mantissa_bits[62:0] == 63'd0) begin
        norm.spec_bits = INF_BITS;
      end else begin
        norm.spec_bits = QNAN_BITS | {12'd0, mantissa_bits[62:11]};
      end
    end else if (e == 15'd0 || mantissa_bits == 64'd0) begin
      norm.cls = CLS_ZERO;
    end else begin
      norm.cls = CLS_NUM;
    end
  end
endmodule

### hw/rtl/etd_round.sv
// round a normalized value to binary64, normal or subnormal
// depends on etd_pkg
module etd_round import etd_pkg::*; (
  input  norm_t       norm,
  output logic [63:0] double_bits
);
  logic [6:0]  sh;
  logic [63:0] q;
  logic [63:0] rem;
  logic [63:0] half;
  logic [63:0] mag;
  logic [63:0] sum;
  logic        up;

  always_comb begin
    // normal range shifts by 11, subnormal by 12 - be
    if (norm.be >= 17'sd1) begin
      sh = 7'd11;
    end else if (norm.be <= -17'sd53) begin
      sh = 7'd65;
    end else begin
      sh = 7'(17'sd12 - norm.be);
    end
    if (sh >= 7'd65) begin
      q = 64'd0;
      rem = 64'd0;
      half = 64'd1;
    end else if (sh == 7'd64) begin
      q = 64'd0;
      rem = norm.mant;
      half = 64'h8000_0000_0000_0000;
    end else begin
      q = norm.mant >> sh[5:0];
      rem = norm.mant & ((64'd1 << sh[5:0]) - 64'd1);
      half = 64'd1 << (sh[5:0] - 6'd1);
    end
    up = (rem > half) || (rem == half && q[0]);
    if (norm.be >= 17'sd1) begin
      sum = {1'b0, 11'(norm.be - 17'sd1), 52'd0} + q + {63'd0, up};
    end else begin
      sum = q + {63'd0, up};
    end
    if (norm.be >= 17'sd2047 || sum >= INF_BITS) begin
      mag = INF_BITS;
    end else begin
      mag = sum;
    end
    case (norm.cls)
      CLS_SPEC: double_bits = {norm.sign, norm.spec_bits[62:0]};
      CLS_NUM:  double_bits = {norm.sign, mag[62:0]};
      default:  double_bits = {norm.sign, 63'd0};
    endcase
  end
endmodule

### sim/extended_to_double_convert_test.sv
// self-checking bench for the extended (80-bit) to binary64 converter
// predicts each result in a scoreboard class and checks every done strobe
// depends on etd_pkg and extended_to_double_convert
`timescale 1ns / 100ps

module extended_to_double_convert_test;
  import etd_pkg::*;

  localparam int EXT_BIAS = 16383;
  localparam int DBL_BIAS = 1023;
  localparam int DBL_EXP_MAX = 2047;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] mantissa_bits;
  logic [15:0] sign_exponent;
  logic        done;
  logic [63:0] double_bits;

  int mismatch_count = 0;
  int idle_cycles = 0;

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // round to nearest even of m shifted right by sh
  function automatic logic [63:0] round_shift(input logic [63:0] m, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (sh >= 65) return 64'd0;
    if (sh == 64) begin
      q = 64'd0;
      rem = m;
      half = 64'h8000_0000_0000_0000;
    end else begin
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
    end
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // binary64 pattern of the extended value
  function automatic logic [63:0] to_double(input logic [63:0] m, input logic [15:0] se);
    logic [63:0] sgn;
    logic [14:0] ex;
    logic [63:0] q;
    logic [63:0] bits;
    int lz;
    int be;
    sgn = {se[15], 63'd0};
    ex = se[14:0];
    if (ex == EXT_EXP_MAX) begin
      if (m[62:0] == 63'd0) return sgn | INF_BITS;
      return sgn | QNAN_BITS | {12'd0, m[62:11]};
    end
    if (ex == 15'd0 || m == 64'd0) return sgn;
    // leading-zero count for unnormals
    lz = 0;
    while (!m[63]) begin
      m = m << 1;
      lz++;
    end
    be = int'(ex) - EXT_BIAS + DBL_BIAS - lz;
    if (be >= DBL_EXP_MAX) return sgn | INF_BITS;
    if (be >= 1) begin
      q = round_shift(m, 11);
      bits = (64'(be - 1) << 52) + q;
      if (bits >= INF_BITS) bits = INF_BITS;
      return sgn | bits;
    end
    // subnormal range
    return sgn | round_shift(m, 12 - be);
  endfunction

  class convert_scoreboard;
    logic [63:0] pending_doubles[$];

    function void note_transfer(logic [63:0] m, logic [15:0] se);
      pending_doubles = {pending_doubles, to_double(m, se)};
    endfunction

    task check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending_doubles.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_doubles.pop_front();
        if (got !== want)
          report_mismatch($sformatf("double_bits %h, expected %h", got, want));
      end
    endtask
  endclass

  convert_scoreboard board = new();

  extended_to_double_convert dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mantissa_bits(mantissa_bits),
    .sign_exponent(sign_exponent),
    .done(done),
    .double_bits(double_bits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: inputs and results sampled at the edge, before the new drive lands
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_transfer(mantissa_bits, sign_exponent);
      if (done) board.check_result(double_bits);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one transfer: hold start until it is taken, leave start high for the next
  task automatic send_value(input logic [63:0] m, input logic [15:0] se);
    start <= 1'b1;
    mantissa_bits <= m;
    sign_exponent <= se;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      mantissa_bits <= {$urandom, $urandom};
      sign_exponent <= 16'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // random exponent weighted toward the interesting ranges
  function automatic logic [14:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return 15'd0;
      1:       return EXT_EXP_MAX;
      2:       return 15'($urandom_range(EXT_BIAS - 1022 - 70, EXT_BIAS - 1022 + 2));
      3:       return 15'($urandom_range(EXT_BIAS + 1023 - 2, EXT_BIAS + 1023 + 2));
      4:       return 15'($urandom);
      default: return 15'($urandom_range(EXT_BIAS - 1000, EXT_BIAS + 1000));
    endcase
  endfunction

  // significand shapes: normal, unnormal, single set bit, tie patterns, all ones
  function automatic logic [63:0] pick_mantissa();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: m = m >> $urandom_range(1, 63);
      1: m = {1'b1, m[62:11], 1'b1, 10'd0};
      2: m = {1'b1, m[62:11], 11'h7FF};
      3: m = 64'hFFFF_FFFF_FFFF_FFFF;
      4: m = {1'b0, m[62:0]};
      5: m = 64'd1 << $urandom_range(0, 63);
      default: m[63] = 1'b1;
    endcase
    return m;
  endfunction

  initial begin
    int burst;
    rst = 1'b1;
    start = 1'b0;
    mantissa_bits = 64'd0;
    sign_exponent = 16'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zeros, infinity, nan, overflow, subnormals, ties, unnormals
    send_value(64'h8000_0000_0000_0000, 16'd0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 16'h8000);
    send_value(64'd0, 16'h3FFF);
    send_value(64'd0, 16'hC123);
    send_value(64'h8000_0000_0000_0000, 16'h7FFF);
    send_value(64'h0000_0000_0000_0000, 16'hFFFF);
    send_value(64'hC000_0000_0000_0000, 16'h7FFF);
    send_value(64'h0000_0000_0000_0001, 16'hFFFF);
    send_value(64'h4000_0000_0000_0800, 16'h7FFF);
    send_value(64'h8000_0000_0000_0000, 16'h3FFF);
    send_value(64'h8000_0000_0000_0400, 16'h3FFF);
    send_value(64'h8000_0000_0000_0C00, 16'h3FFF);
    send_value(64'hFFFF_FFFF_FFFF_FC00, 16'h43FE);
    send_value(64'hFFFF_FFFF_FFFF_F800, 16'h43FE);
    send_value(64'h8000_0000_0000_0000, 16'h43FF);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFE);
    send_value(64'h8000_0000_0000_0000, 16'(EXT_BIAS - 1022));
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 16'(EXT_BIAS - 1023));
    send_value(64'h8000_0000_0000_0000, 16'(EXT_BIAS - 1074));
    send_value(64'h8000_0000_0000_0000, 16'(EXT_BIAS - 1075));
    send_value(64'h8000_0000_0000_0001, 16'(EXT_BIAS - 1075));
    send_value(64'h8000_0000_0000_0000, 16'(EXT_BIAS - 1076));
    send_value(64'h0000_0000_0000_0001, 16'h3FFF);
    send_value(64'h0000_0000_0000_0001, 16'h0001);
    send_value(64'h5555_5555_5555_5555, 16'hAAAA);

    // random bursts with gaps, some long stretches with no gap
    while (burst < RANDOM_ITEMS) begin
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (len) send_value(pick_mantissa(), {1'($urandom), pick_exponent()});
      burst += len;
      pause_sender($urandom_range(0, 4));
    end
    start <= 1'b0;

    @(posedge clk);
    while (board.pending_doubles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && board.pending_doubles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### extended_to_double_convert.f
+incdir+hw/rtl
hw/rtl/etd_pkg.sv
hw/rtl/etd_normalize.sv
hw/rtl/etd_round.sv
hw/rtl/extended_to_double_convert.sv
sim/extended_to_double_convert_test.sv
